>>> hdl/aabb_pkg.sv
// ---------------------------------------------------------------------------
// aabb_pkg: shared types and constants
// Types and fixed constants used by the box projection core and its divider.
// ---------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

   // Status that travels with one corner through the pipeline.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic near;
   } tag_type;

   // NDC magnitudes saturate at 2^NDC_SAT_BITS raw units.
   localparam int NDC_SAT_BITS = 40;
   localparam int NDC_W        = NDC_SAT_BITS + 2;
   localparam int DIV_STEPS    = 2;
   localparam int FIFO_DEPTH   = 8;
   localparam int FIFO_AW      = 3;
   localparam int CSR_IDX_W    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_4   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_5   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_SIZE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MIP    = 3'd7;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -33'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/aabb_div.sv
// ---------------------------------------------------------------------------
// aabb_div: pipelined NDC divider
// Divides clip x and clip y by clip w, truncating toward zero, with
// FRAC_BITS fraction bits and magnitudes saturated at 2^40 raw units.
// ---------------------------------------------------------------------------
`default_nettype none

module aabb_div import aabb_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  tag_type                     in_tag,
   input  wire logic signed [65-FRAC_BITS:0] in_num_x,
   input  wire logic signed [65-FRAC_BITS:0] in_num_y,
   input  wire logic signed [65-FRAC_BITS:0] in_w,
   output tag_type                     out_tag,
   output logic signed [NDC_W-1:0]     out_ndc_x,
   output logic signed [NDC_W-1:0]     out_ndc_y
);

   localparam int CLIP_W = 66 - FRAC_BITS;
   localparam int D_W    = CLIP_W + FRAC_BITS;
   localparam int HI_W   = D_W - NDC_SAT_BITS;
   localparam int CMP_W  = CLIP_W + NDC_SAT_BITS;
   localparam int N_ST   = NDC_SAT_BITS / DIV_STEPS;

   logic [CLIP_W-1:0]       rem_ff [0:N_ST][2];
   logic [NDC_SAT_BITS-1:0] low_ff [0:N_ST][2];
   logic [NDC_SAT_BITS-1:0] q_ff   [0:N_ST][2];
   logic                    neg_ff [0:N_ST][2];
   logic                    sat_ff [0:N_ST][2];
   logic [CLIP_W-1:0]       w_ff   [0:N_ST];
   tag_type                 tag_ff [0:N_ST];

   logic [CLIP_W-1:0]       rem_in [1:N_ST][2];
   logic [NDC_SAT_BITS-1:0] low_in [1:N_ST][2];
   logic [NDC_SAT_BITS-1:0] q_in   [1:N_ST][2];

   logic signed [CLIP_W-1:0] num0 [2];
   logic [CLIP_W-1:0]        un0  [2];
   logic [D_W-1:0]           dvd0 [2];
   logic                     sat0 [2];

   logic signed [NDC_W-1:0]  ndc_x_ff, ndc_y_ff, ndc_in [2];
   tag_type                  out_tag_ff;

   always_comb begin
      num0[0] = in_num_x;
      num0[1] = in_num_y;
      for (int l = 0; l < 2; l++) begin
         un0[l]  = num0[l][CLIP_W-1] ? CLIP_W'(-num0[l]) : CLIP_W'(num0[l]);
         dvd0[l] = {un0[l], {FRAC_BITS{1'b0}}};
         // Saturate when the quotient would reach 2^40.
         sat0[l] = CMP_W'(dvd0[l]) >= {in_w, {NDC_SAT_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0].valid <= 1'b0;
      end else begin
         tag_ff[0] <= in_tag;
      end
      w_ff[0] <= in_w;
      for (int l = 0; l < 2; l++) begin
         rem_ff[0][l] <= {{(CLIP_W-HI_W){1'b0}}, dvd0[l][D_W-1:NDC_SAT_BITS]};
         low_ff[0][l] <= dvd0[l][NDC_SAT_BITS-1:0];
         q_ff[0][l]   <= '0;
         neg_ff[0][l] <= num0[l][CLIP_W-1];
         sat_ff[0][l] <= sat0[l];
      end
   end

   for (genvar s = 1; s <= N_ST; s++) begin : g_stage
      always_comb begin : step
         logic [CLIP_W-1:0]       r;
         logic [NDC_SAT_BITS-1:0] lo;
         logic [NDC_SAT_BITS-1:0] q;
         for (int l = 0; l < 2; l++) begin
            r  = rem_ff[s-1][l];
            lo = low_ff[s-1][l];
            q  = q_ff[s-1][l];
            for (int k = 0; k < DIV_STEPS; k++) begin
               r  = {r[CLIP_W-2:0], lo[NDC_SAT_BITS-1]};
               lo = {lo[NDC_SAT_BITS-2:0], 1'b0};
               if (r >= w_ff[s-1]) begin
                  r = r - w_ff[s-1];
                  q = {q[NDC_SAT_BITS-2:0], 1'b1};
               end else begin
                  q = {q[NDC_SAT_BITS-2:0], 1'b0};
               end
            end
            rem_in[s][l] = r;
            low_in[s][l] = lo;
            q_in[s][l]   = q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[s].valid <= 1'b0;
         end else begin
            tag_ff[s] <= tag_ff[s-1];
         end
         w_ff[s] <= w_ff[s-1];
         for (int l = 0; l < 2; l++) begin
            rem_ff[s][l] <= rem_in[s][l];
            low_ff[s][l] <= low_in[s][l];
            q_ff[s][l]   <= q_in[s][l];
            neg_ff[s][l] <= neg_ff[s-1][l];
            sat_ff[s][l] <= sat_ff[s-1][l];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         ndc_in[l] = sat_ff[N_ST][l] ? (NDC_W'(1) <<< NDC_SAT_BITS)
                                     : $signed({2'b00, q_ff[N_ST][l]});
         if (neg_ff[N_ST][l]) begin
            ndc_in[l] = -ndc_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_tag_ff.valid <= 1'b0;
      end else begin
         out_tag_ff <= tag_ff[N_ST];
      end
      ndc_x_ff <= ndc_in[0];
      ndc_y_ff <= ndc_in[1];
   end

   assign out_tag   = out_tag_ff;
   assign out_ndc_x = ndc_x_ff;
   assign out_ndc_y = ndc_y_ff;

endmodule

`default_nettype wire

>>> hdl/aabb_screen_mip_select_core.sv
// ---------------------------------------------------------------------------
// aabb_screen_mip_select_core: screen-space mip selection for a cube
// Projects the eight corners of a box, forms its screen rectangle and
// returns the pyramid level that covers it.
// ---------------------------------------------------------------------------
//   Channel   Dir   Payload
//   req_*     in    center_x, center_y, center_z, half_extent
//   rsp_*     out   mip_level (tdata), near_clipped (tuser)
//   csr_*     in    register index and write data
//
// The corner sequencer issues the eight corners of a request, one corner per
// cycle, into the shared transform and divide pipeline. Reset is
// synchronous. The pipeline never stalls; responses queue in an 8-entry
// buffer and requests are taken while the buffer has room for them and the
// sequencer is idle or on its last corner.
// ---------------------------------------------------------------------------
`default_nettype none

module aabb_screen_mip_select_core import aabb_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   // center_x[31:0], center_y[63:32], center_z[95:64], half_extent[126:96]
   input  wire [127:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   // mip_level[3:0]
   output logic [7:0]           rsp_tdata,
   // near_clipped[0]
   output logic [0:0]           rsp_tuser,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [63:0]           csr_wdata
);

   localparam int SH_W   = 64 - FRAC_BITS;
   localparam int CLIP_W = SH_W + 2;
   localparam int EPS    = ((1 << FRAC_BITS) + 5000) / 10000;
   localparam logic signed [CLIP_W-1:0] EPS_Q = CLIP_W'(EPS);
   localparam int PX_W   = NDC_W + 16;
   localparam int E_W    = PX_W - 1;
   localparam int MSB_W  = 6;

   // Configuration.
   logic signed [31:0] coef_ff [12];
   logic [31:0]        image_size_ff;
   logic [3:0]         max_mip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 12; i++) begin
            coef_ff[i] <= '0;
         end
         image_size_ff <= '0;
         max_mip_ff    <= 4'd15;
      end else if (csr_we) begin
         unique case (csr_index) inside
            CSR_MATRIX_0, CSR_MATRIX_1, CSR_MATRIX_2,
            CSR_MATRIX_3, CSR_MATRIX_4, CSR_MATRIX_5: begin
               for (int i = 0; i < 6; i++) begin
                  if (csr_index == CSR_IDX_W'(i)) begin
                     coef_ff[2*i]   <= csr_wdata[31:0];
                     coef_ff[2*i+1] <= csr_wdata[63:32];
                  end
               end
            end
            CSR_IMAGE_SIZE: image_size_ff <= csr_wdata[31:0];
            CSR_MAX_MIP:    max_mip_ff    <= csr_wdata[3:0];
         endcase
      end
   end

   // Corner sequencer.
   logic                busy_ff;
   logic [2:0]          corner_ff;
   logic [3:0]          credit_ff;
   logic signed [31:0]  cx_ff, cy_ff, cz_ff;
   logic [30:0]         h_ff;
   logic                accept, pop;

   assign req_tready = (!busy_ff || corner_ff == 3'd7) &&
                       (credit_ff < 4'(FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         corner_ff <= '0;
         credit_ff <= '0;
      end else begin
         if (accept) begin
            busy_ff   <= 1'b1;
            corner_ff <= '0;
         end else if (busy_ff) begin
            corner_ff <= corner_ff + 3'd1;
            if (corner_ff == 3'd7) begin
               busy_ff <= 1'b0;
            end
         end
         credit_ff <= credit_ff + 4'(accept) - 4'(pop);
      end
      if (accept) begin
         cx_ff <= req_tdata[31:0];
         cy_ff <= req_tdata[63:32];
         cz_ff <= req_tdata[95:64];
         h_ff  <= req_tdata[126:96];
      end
   end

   // Stage 0: corner coordinates.
   logic signed [32:0] hs;
   logic signed [31:0] p_in [3], p_ff [3];
   tag_type            s0_tag_ff;

   always_comb begin
      hs      = $signed({2'b00, h_ff});
      p_in[0] = sat32(corner_ff[2] ? 33'(cx_ff) + hs : 33'(cx_ff) - hs);
      p_in[1] = sat32(corner_ff[1] ? 33'(cy_ff) + hs : 33'(cy_ff) - hs);
      p_in[2] = sat32(corner_ff[0] ? 33'(cz_ff) + hs : 33'(cz_ff) - hs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_tag_ff.valid <= 1'b0;
      end else begin
         s0_tag_ff.valid <= busy_ff;
         s0_tag_ff.first <= corner_ff == 3'd0;
         s0_tag_ff.last  <= corner_ff == 3'd7;
         s0_tag_ff.near  <= 1'b0;
      end
      p_ff <= p_in;
   end

   // Stage 1: the nine products of the x, y and w rows.
   logic signed [63:0] prod_ff [3][3];
   tag_type            s1_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff.valid <= 1'b0;
      end else begin
         s1_tag_ff <= s0_tag_ff;
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[r][c] <= coef_ff[4*r+c] * p_ff[c];
         end
      end
   end

   // Stage 2: floor shift of each product, row sums and the near test.
   logic signed [SH_W-1:0]   sh [3][3];
   logic signed [CLIP_W-1:0] clip_in [3], clip_ff [3];
   tag_type                  s2_tag_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            sh[r][c] = SH_W'(prod_ff[r][c] >>> FRAC_BITS);
         end
         clip_in[r] = CLIP_W'(sh[r][0]) + CLIP_W'(sh[r][1]) + CLIP_W'(sh[r][2]) +
                      CLIP_W'(coef_ff[4*r+3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff.valid <= 1'b0;
      end else begin
         s2_tag_ff.valid <= s1_tag_ff.valid;
         s2_tag_ff.first <= s1_tag_ff.first;
         s2_tag_ff.last  <= s1_tag_ff.last;
         s2_tag_ff.near  <= clip_in[2] <= EPS_Q;
      end
      clip_ff <= clip_in;
   end

   // Division by w.
   tag_type                 dv_tag;
   logic signed [NDC_W-1:0] ndc_x, ndc_y;

   aabb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (s2_tag_ff),
      .in_num_x  (clip_ff[0]),
      .in_num_y  (clip_ff[1]),
      .in_w      (clip_ff[2]),
      .out_tag   (dv_tag),
      .out_ndc_x (ndc_x),
      .out_ndc_y (ndc_y)
   );

   // Bounding rectangle over the eight corners.
   logic signed [NDC_W-1:0] minx_ff, maxx_ff, miny_ff, maxy_ff;
   logic signed [NDC_W-1:0] minx_in, maxx_in, miny_in, maxy_in;
   logic                    near_ff, near_in;
   logic signed [NDC_W-1:0] f1_minx_ff, f1_maxx_ff, f1_miny_ff, f1_maxy_ff;
   logic                    f1_valid_ff, f1_near_ff;

   always_comb begin
      minx_in = (dv_tag.first || ndc_x < minx_ff) ? ndc_x : minx_ff;
      maxx_in = (dv_tag.first || ndc_x > maxx_ff) ? ndc_x : maxx_ff;
      miny_in = (dv_tag.first || ndc_y < miny_ff) ? ndc_y : miny_ff;
      maxy_in = (dv_tag.first || ndc_y > maxy_ff) ? ndc_y : maxy_ff;
      near_in = dv_tag.first ? dv_tag.near : (near_ff || dv_tag.near);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= dv_tag.valid && dv_tag.last;
      end
      if (dv_tag.valid) begin
         minx_ff <= minx_in;
         maxx_ff <= maxx_in;
         miny_ff <= miny_in;
         maxy_ff <= maxy_in;
         near_ff <= near_in;
      end
      f1_minx_ff <= minx_in;
      f1_maxx_ff <= maxx_in;
      f1_miny_ff <= miny_in;
      f1_maxy_ff <= maxy_in;
      f1_near_ff <= near_in;
   end

   // Spans, texel extents, larger extent.
   logic [NDC_W-1:0] dx_ff, dy_ff;
   logic             f2_valid_ff, f2_near_ff;
   logic [E_W-1:0]   ex_ff, ey_ff, e_ff;
   logic             f3_valid_ff, f3_near_ff, f4_valid_ff, f4_near_ff;
   logic [PX_W-1:0]  px_prod, py_prod;

   assign px_prod = dx_ff * image_size_ff[15:0];
   assign py_prod = dy_ff * image_size_ff[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else begin
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
      dx_ff      <= NDC_W'(f1_maxx_ff - f1_minx_ff);
      dy_ff      <= NDC_W'(f1_maxy_ff - f1_miny_ff);
      f2_near_ff <= f1_near_ff;
      ex_ff      <= px_prod[PX_W-1:1];
      ey_ff      <= py_prod[PX_W-1:1];
      f3_near_ff <= f2_near_ff;
      e_ff       <= (ex_ff > ey_ff) ? ex_ff : ey_ff;
      f4_near_ff <= f3_near_ff;
   end

   // Level: top set bit less the fraction width, capped; zero for a near-clipped box or an extent of at most 1.0.
   logic [MSB_W-1:0] msb, lvl_raw;
   logic [3:0]       level;

   always_comb begin
      msb = '0;
      for (int i = 0; i < E_W; i++) begin
         if (e_ff[i]) begin
            msb = MSB_W'(i);
         end
      end
      lvl_raw = msb - MSB_W'(FRAC_BITS);
      if (f4_near_ff || e_ff <= (E_W'(1) << FRAC_BITS)) begin
         level = '0;
      end else if (lvl_raw > {2'b00, max_mip_ff}) begin
         level = max_mip_ff;
      end else begin
         level = lvl_raw[3:0];
      end
   end

   // Response buffer.
   logic [4:0]         fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wptr_ff, rptr_ff;
   logic [FIFO_AW:0]   count_ff;

   assign rsp_tvalid = count_ff != '0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {4'b0000, fifo_mem[rptr_ff][4:1]};
   assign rsp_tuser  = fifo_mem[rptr_ff][0];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (f4_valid_ff) begin
            wptr_ff <= wptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + FIFO_AW'(1);
         end
         count_ff <= count_ff + (FIFO_AW+1)'(f4_valid_ff) - (FIFO_AW+1)'(pop);
      end
      if (f4_valid_ff) begin
         fifo_mem[wptr_ff] <= {level, f4_near_ff};
      end
   end

endmodule

`default_nettype wire

>>> test/aabb_screen_mip_select_core_tb.sv
// ---------------------------------------------------------------------------
// aabb_screen_mip_select_core_tb: self-checking bench for the mip selector
// Drives cube requests through the core under several matrix, image size
// and level cap settings, predicts each level and near flag in the bench,
// and compares every response in order against the predicted queue.
// ---------------------------------------------------------------------------
`default_nettype none

module aabb_screen_mip_select_core_tb import aabb_pkg::*; ();

   localparam int FRAC = 16;
   localparam longint EPS_RAW = ((64'd1 << FRAC) + 5000) / 10000;
   localparam longint NDC_SAT = 64'd1 << NDC_SAT_BITS;

   typedef struct packed {
      logic [3:0] level;
      logic       near;
   } mip_result_type;

   typedef struct {
      logic [31:0]    cx, cy, cz;
      logic [30:0]    half;
      logic           known;
      mip_result_type res;
   } box_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   longint         coeff [12];
   logic [31:0]    img_dims;
   logic [3:0]     level_cap;
   mip_result_type level_queue[$];
   int             error_count = 0;
   int             rsp_wait = 0;
   logic           stim_done = 1'b0;
   logic           holdoff_done = 1'b0;

   aabb_screen_mip_select_core #(.FRAC_BITS(FRAC)) i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #100000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic longint floor_shift(input longint v);
      return v >>> FRAC;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint project_row(input int base, input longint x, y, z);
      return floor_shift(coeff[base] * x) + floor_shift(coeff[base+1] * y) +
             floor_shift(coeff[base+2] * z) + coeff[base+3];
   endfunction

   // Truncating divide with the magnitude limited to the NDC saturation.
   function automatic longint ndc_of(input longint num, input longint w);
      logic neg;
      longint unsigned un, q, r, mag;
      neg = num < 0;
      un = neg ? -num : num;
      q = un / w;
      r = un % w;
      if (q >= (NDC_SAT >> FRAC)) mag = NDC_SAT;
      else begin
         mag = (q << FRAC) + ((r << FRAC) / w);
         if (mag > NDC_SAT) mag = NDC_SAT;
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic mip_result_type predict_mip(input logic [31:0] cx, cy, cz,
                                                  input logic [30:0] half);
      mip_result_type r;
      longint h, px, py, pz, w, nx, ny, minx, maxx, miny, maxy;
      longint unsigned ex, ey, e, lvl;
      int msb;
      h = longint'({33'd0, half});
      minx = 0; maxx = 0; miny = 0; maxy = 0;
      for (int c = 0; c < 8; c++) begin
         px = clamp32(longint'(signed'(cx)) + (c[2] ? h : -h));
         py = clamp32(longint'(signed'(cy)) + (c[1] ? h : -h));
         pz = clamp32(longint'(signed'(cz)) + (c[0] ? h : -h));
         w = project_row(8, px, py, pz);
         if (w <= EPS_RAW) begin
            r.level = 4'd0;
            r.near = 1'b1;
            return r;
         end
         nx = ndc_of(project_row(0, px, py, pz), w);
         ny = ndc_of(project_row(4, px, py, pz), w);
         if (c == 0 || nx < minx) minx = nx;
         if (c == 0 || nx > maxx) maxx = nx;
         if (c == 0 || ny < miny) miny = ny;
         if (c == 0 || ny > maxy) maxy = ny;
      end
      ex = (longint'(maxx - minx) * img_dims[15:0]) >> 1;
      ey = (longint'(maxy - miny) * img_dims[31:16]) >> 1;
      e = ex > ey ? ex : ey;
      lvl = 0;
      if (e > (64'd1 << FRAC)) begin
         msb = 63;
         while (msb > 0 && e[msb] == 1'b0) msb--;
         lvl = 64'(msb - FRAC);
      end
      if (lvl > level_cap) lvl = 64'(level_cap);
      r.level = lvl[3:0];
      r.near = 1'b0;
      return r;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx < CSR_IMAGE_SIZE) begin
         coeff[idx*2] = longint'(signed'(val[31:0]));
         coeff[idx*2+1] = longint'(signed'(val[63:32]));
      end else if (idx == CSR_IMAGE_SIZE) img_dims = val[31:0];
      else level_cap = val[3:0];
   endtask

   // Rows of the matrix: x = (m0 m4 m8 m12), y = (m1 m5 m9 m13), w = (m3 m7 m11 m15).
   task automatic load_matrix(input logic [31:0] m0, m4, m8, m12, m1, m5, m9, m13,
                              m3, m7, m11, m15);
      write_reg(CSR_MATRIX_0, {m4, m0});
      write_reg(CSR_MATRIX_1, {m12, m8});
      write_reg(CSR_MATRIX_2, {m5, m1});
      write_reg(CSR_MATRIX_3, {m13, m9});
      write_reg(CSR_MATRIX_4, {m7, m3});
      write_reg(CSR_MATRIX_5, {m15, m11});
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (level_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Valid stays high from one request to the next when no idle cycles are drawn.
   task automatic send_box(input logic [31:0] cx, cy, cz, input logic [30:0] half,
                           input logic known, input mip_result_type res);
      mip_result_type p;
      int idle;
      idle = $urandom_range(0, 18);
      if (idle != 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tdata <= {1'b0, half, cz, cy, cx};
      req_tvalid <= 1'b1;
      p = predict_mip(cx, cy, cz, half);
      if (known && p != res) report_mismatch($sformatf("table row disagrees: %p", res));
      level_queue.push_back(p);
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h0;
         default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom;
         default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      endcase
   endfunction

   // Response side: a random wait before each response, in-order compare.
   always @(posedge clock) begin
      mip_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = $urandom_range(0, 18);
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (level_queue.size() == 0) report_mismatch("response with none expected");
            else begin
               want = level_queue.pop_front();
               if (rsp_tdata[3:0] != want.level)
                  report_mismatch($sformatf("level %0d, want %0d", rsp_tdata[3:0],
                                            want.level));
               if (rsp_tdata[7:4] != 4'd0) report_mismatch("tdata padding nonzero");
               if (rsp_tuser[0] != want.near)
                  report_mismatch($sformatf("near %0b, want %0b", rsp_tuser[0],
                                            want.near));
            end
            rsp_wait = $urandom_range(0, 18);
         end else if (rsp_tvalid && rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0) || stim_done;
      end
   end

   box_row_type boxes[$];
   localparam logic [31:0] ONE = 32'h0001_0000;

   initial begin
      box_row_type row;
      for (int i = 0; i < 12; i++) coeff[i] = 0;
      img_dims = '0;
      level_cap = 4'd15;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // After reset every w is zero, so each box is near clipped.
      row = '{32'h7fffffff, 32'h80000000, 32'h0, 31'h7fffffff, 1'b1, '{4'd0, 1'b1}};
      boxes.push_back(row);
      row = '{32'h0, 32'h0, 32'h0, 31'h0, 1'b1, '{4'd0, 1'b1}};
      boxes.push_back(row);
      foreach (boxes[i])
         send_box(boxes[i].cx, boxes[i].cy, boxes[i].cz, boxes[i].half, 1'b1, boxes[i].res);
      wait_drained();

      // Identity-like projection, w = z.
      load_matrix(ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0);
      write_reg(CSR_IMAGE_SIZE, 64'({16'hffff, 16'hffff}));
      write_reg(CSR_MAX_MIP, 64'd15);
      boxes.delete();
      row = '{32'h0, 32'h0, 32'h0010_0000, 31'h0001_0000, 1'b0, '{4'd0, 1'b0}};
      boxes.push_back(row);
      // Box reaching behind the eye: near clipped.
      row = '{32'h0, 32'h0, 32'h0, 31'h0001_0000, 1'b1, '{4'd0, 1'b1}};
      boxes.push_back(row);
      row = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 1'b0, '{4'd0, 1'b0}};
      boxes.push_back(row);
      row = '{32'h80000000, 32'h80000000, 32'h7fff0000, 31'h7fff0000, 1'b0, '{4'd0, 1'b0}};
      boxes.push_back(row);
      row = '{32'h0, 32'h0, 32'h0100_0000, 31'h0, 1'b1, '{4'd0, 1'b0}};
      boxes.push_back(row);
      row = '{32'h0, 32'h0, 32'h0000_0100, 31'h0000_0080, 1'b0, '{4'd0, 1'b0}};
      boxes.push_back(row);
      row = '{32'h7fff0000, 32'h0, 32'h0000_1000, 31'h0000_0010, 1'b0, '{4'd0, 1'b0}};
      boxes.push_back(row);
      row = '{32'h5555aaaa, 32'haaaa5555, 32'h0020_0000, 31'h2aaa5555, 1'b0, '{4'd0, 1'b0}};
      boxes.push_back(row);
      foreach (boxes[i])
         send_box(boxes[i].cx, boxes[i].cy, boxes[i].cz, boxes[i].half,
                  boxes[i].known, boxes[i].res);
      wait_drained();

      // Level capped at zero, and a zero image size.
      write_reg(CSR_MAX_MIP, 64'd0);
      send_box(32'h0, 32'h0, 32'h0002_0000, 31'h0001_0000, 1'b1, '{4'd0, 1'b0});
      wait_drained();
      write_reg(CSR_MAX_MIP, 64'd7);
      write_reg(CSR_IMAGE_SIZE, 64'd0);
      send_box(32'h0, 32'h0, 32'h0002_0000, 31'h0001_0000, 1'b1, '{4'd0, 1'b0});
      wait_drained();
      // Extreme coefficients.
      load_matrix(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  0, 0, 0, 32'h7fffffff);
      write_reg(CSR_IMAGE_SIZE, 64'hffff_ffff_ffff_ffff);
      write_reg(CSR_MAX_MIP, 64'hf);
      send_box(32'h0001_0000, 32'hffff_0000, 32'h0, 31'h0000_8000, 1'b0, '{4'd0, 1'b0});
      send_box(32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 1'b0,
               '{4'd0, 1'b0});
      wait_drained();

      // Random phases, each with a fresh matrix and settings.
      for (int ph = 0; ph < 14; ph++) begin
         load_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                     rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                     rand_coef(), rand_coef(), $urandom_range(0, 32'h0002_0000),
                     $urandom_range(0, 32'h0100_0000));
         write_reg(CSR_IMAGE_SIZE, {$urandom, $urandom});
         write_reg(CSR_MAX_MIP, {$urandom, $urandom});
         for (int n = 0; n < 100; n++) begin
            send_box(rand_coord(), rand_coord(),
                     $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000),
                     31'($urandom_range(0, 3) == 0 ? $urandom
                                                   : $urandom_range(0, 32'h0008_0000)),
                     1'b0, '{4'd0, 1'b0});
            if (n == 50 && !holdoff_done) begin
               req_tvalid <= 1'b0;
               while (level_queue.size() != 0) @(posedge clock);
               holdoff_done = 1'b1;
            end
         end
         wait_drained();
      end

      stim_done = 1'b1;
      fork
         begin
            while (level_queue.size() != 0) @(posedge clock);
            repeat (100) @(posedge clock);
         end
         begin
            repeat (20000) @(posedge clock);
         end
      join_any
      if (error_count == 0 && level_queue.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
